// File: rtl/counting_semaphore_table_defines.svh
// Assertion macros shared by the semaphore table RTL.
`ifndef COUNTING_SEMAPHORE_TABLE_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cst_pkg.sv
// Shared widths, default sizes and operation/result codes of the semaphore table.
package cst_pkg;

	localparam int FUNC_W  = 3;
	localparam int ID_W    = 5;
	localparam int COUNT_W = 16;
	localparam int PID_W   = 16;
	localparam int RC_W    = 3;

	localparam int NUM_SEMS_DEF    = 16;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PID_BITS_DEF    = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_CREATE = 3'd0,
		FN_WAIT   = 3'd1,
		FN_POST   = 3'd2,
		FN_DELETE = 3'd3,
		FN_OPEN   = 3'd4
	} func_t;

	typedef enum logic [RC_W-1:0] {
		RC_OK       = 3'd0,
		RC_INVALID  = 3'd1,
		RC_EXISTS   = 3'd2,
		RC_NOT_OPEN = 3'd3,
		RC_FULL     = 3'd4
	} rc_t;

endpackage

// File: rtl/cst_ifs.sv
// Request and response channel interfaces of the semaphore table.
interface cst_req_if;
	logic                              valid;
	logic                              ready;
	logic [cst_pkg::FUNC_W-1:0]        func;
	logic [cst_pkg::ID_W-1:0]          sem_id;
	logic signed [cst_pkg::COUNT_W-1:0] init_count;
	logic [cst_pkg::PID_W-1:0]         caller_pid;

	modport source (output valid, func, sem_id, init_count, caller_pid, input ready);
	modport sink   (input valid, func, sem_id, init_count, caller_pid, output ready);
endinterface

interface cst_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [cst_pkg::RC_W-1:0]   result_code;
	logic                       caller_blocks;
	logic                       wake_valid;
	logic [cst_pkg::PID_W-1:0]  wake_pid;
	logic                       last;

	modport source (output valid, result_code, caller_blocks, wake_valid, wake_pid, last,
		input ready);
	modport sink   (input valid, result_code, caller_blocks, wake_valid, wake_pid, last,
		output ready);
endinterface

// File: rtl/cst_pid_ram.sv
// Wait-queue pid storage: one write port, one registered read port.
module cst_pid_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/counting_semaphore_table.sv
// Counting semaphore table: top level with metadata store and request sequencer.
//
// Usage
//   req (sink): one request per handshake: func, sem_id, init_count, caller_pid.
//   rsp (source): result items; every request yields one item, except a
//   delete of a semaphore with n queued pids, which yields n items (one wake
//   each, oldest first). Only the final item of a request carries last = 1.
// Timing
//   A request is taken and its semaphore entry is read from the metadata RAM
//   on the accept edge; in ST_META the entry is modified and written back and
//   the result is registered, and in ST_RESP it is loaded into the output
//   register. The next request is taken on the same edge that loads the
//   result. A delete streams its wakes at one per cycle out of the pid RAM
//   read port while rsp is not stalled. The metadata read-modify-write loop
//   sets the pace.
// Reset
//   arst_n clears all semaphore entries at once (per-entry valid bits); the
//   block is ready in the first cycle after reset. No clearing pass.
// Stall
//   While rsp is stalled the result holds in the output register; a further
//   request can still be taken and decided, but its result is not loaded until the held result has been accepted.
module counting_semaphore_table #(
	parameter int NUM_SEMS    = cst_pkg::NUM_SEMS_DEF,
	parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF,
	parameter int PID_BITS    = cst_pkg::PID_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cst_req_if.sink    req,
	cst_rsp_if.source  rsp
);

`include "counting_semaphore_table_defines.svh"

	localparam int CW       = cst_pkg::COUNT_W;
	localparam int PIDW     = cst_pkg::PID_W;
	localparam int SEM_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int HEAD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W    = LEN_W + 1;
	localparam int PQ_DEPTH = NUM_SEMS * QUEUE_DEPTH;
	localparam int PA_W     = (PQ_DEPTH > 1) ? $clog2(PQ_DEPTH) : 1;
	// stored pid width: the port is 16 bits, PID_BITS may narrow it
	localparam int PW       = (PID_BITS < PIDW) ? PID_BITS : PIDW;

	// one metadata word per semaphore
	typedef struct packed {
		logic                 exists;
		logic signed [CW-1:0] count;
		logic [HEAD_W-1:0]    head;
		logic [LEN_W-1:0]     len;
	} meta_t;

	typedef enum logic [2:0] {
		ST_IDLE,   // waiting for a request
		ST_META,   // metadata read data valid: decide, write back
		ST_RESP,   // plain result waiting for the output register
		ST_WAKE,   // post dequeued a pid: pid RAM data valid
		ST_DEL     // delete streaming queued pids
	} state_t;

	function automatic logic signed [CW-1:0] sat_cnt(input logic signed [CW:0] v);
		logic signed [CW-1:0] r;
		if (v[CW] != v[CW-1]) begin
			r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	function automatic logic [HEAD_W-1:0] wrap_inc(input logic [HEAD_W-1:0] h);
		logic [HEAD_W-1:0] r;
		r = (h == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : h + HEAD_W'(1);
		return r;
	endfunction

	function automatic logic [PA_W-1:0] pid_addr(input logic [SEM_W-1:0] s,
		input logic [HEAD_W-1:0] slot);
		logic [PA_W-1:0] r;
		r = PA_W'(s) * PA_W'(QUEUE_DEPTH) + PA_W'(slot);
		return r;
	endfunction

	state_t state_q;

	// captured request
	logic [cst_pkg::FUNC_W-1:0] func_q;
	logic                       ok_q;     // id in range and known operation
	logic [SEM_W-1:0]           sem_q;
	logic signed [CW-1:0]       init_q;
	logic [PW-1:0]              pid_q;

	// pending plain result
	cst_pkg::rc_t res_code_q;
	logic         res_blocks_q;

	// delete walk
	logic [LEN_W-1:0]  del_left_q;
	logic [HEAD_W-1:0] del_ptr_q;

	// output register
	logic              rsp_valid_q;
	cst_pkg::rc_t      rsp_code_q;
	logic              rsp_blocks_q;
	logic              rsp_wv_q;
	logic [PIDW-1:0]   rsp_pid_q;
	logic              rsp_last_q;

	// metadata store: RAM plus valid bits (invalid entry reads as all zero)
	meta_t             meta_mem [NUM_SEMS];
	logic [NUM_SEMS-1:0] meta_vld_q;
	meta_t             meta_rdata_q;
	logic              meta_rvld_q;
	meta_t             cur;

	// request decode at the accept edge
	logic              id_ok;
	logic              fn_ok;
	logic [SEM_W-1:0]  acc_idx;
	logic              acc;

	// sequencer outputs
	logic              out_free;
	logic              done;
	logic              meta_we;
	meta_t             meta_wd;
	logic              pid_we;
	logic [PA_W-1:0]   pid_waddr;
	logic              pid_re;
	logic [PA_W-1:0]   pid_raddr;
	logic [PW-1:0]     pid_rdata;
	state_t            meta_nxt;
	cst_pkg::rc_t      res_code_d;
	logic              res_blocks_d;
	logic              del_go;
	logic              out_load;
	cst_pkg::rc_t      out_code_d;
	logic              out_blocks_d;
	logic              out_wv_d;
	logic              out_last_d;

	// count arithmetic on the entry under work
	logic signed [CW:0]   cnt_dec;
	logic signed [CW:0]   cnt_inc;
	logic signed [CW-1:0] inc_sat;
	logic [SUM_W-1:0]     tail_sum;
	logic [HEAD_W-1:0]    tail;
	logic                 q_full;

	assign id_ok   = (req.sem_id != '0) && (int'(req.sem_id) <= NUM_SEMS);
	assign fn_ok   = (req.func <= cst_pkg::FN_OPEN);
	assign acc_idx = id_ok ? SEM_W'(req.sem_id - 5'd1) : '0;

	assign cur = meta_rvld_q ? meta_rdata_q : '0;

	assign cnt_dec  = $signed({cur.count[CW-1], cur.count}) - 17'sd1;
	assign cnt_inc  = $signed({cur.count[CW-1], cur.count}) + 17'sd1;
	assign inc_sat  = sat_cnt(cnt_inc);
	assign tail_sum = SUM_W'(cur.head) + SUM_W'(cur.len);
	// head + len stays below twice the depth: one compare and subtract wraps it
	assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
	assign q_full   = (cur.len == LEN_W'(QUEUE_DEPTH));

	assign out_free = !rsp_valid_q || rsp.ready;
	assign acc      = req.valid && req.ready;

	always_comb begin
		meta_we      = 1'b0;
		meta_wd      = cur;
		pid_we       = 1'b0;
		pid_waddr    = pid_addr(sem_q, tail);
		pid_re       = 1'b0;
		pid_raddr    = pid_addr(sem_q, cur.head);
		meta_nxt     = ST_RESP;
		res_code_d   = cst_pkg::RC_OK;
		res_blocks_d = 1'b0;
		del_go       = 1'b0;
		out_load     = 1'b0;
		out_code_d   = cst_pkg::RC_OK;
		out_blocks_d = 1'b0;
		out_wv_d     = 1'b0;
		out_last_d   = 1'b1;
		done         = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
			end
			ST_META: begin
				if (!ok_q) begin
					res_code_d = cst_pkg::RC_INVALID;
				end else begin
					unique case (func_q)
						cst_pkg::FN_CREATE: begin
							if (cur.exists) begin
								res_code_d = cst_pkg::RC_EXISTS;
							end else begin
								meta_we        = 1'b1;
								meta_wd.exists = 1'b1;
								meta_wd.count  = init_q;
								meta_wd.head   = '0;
								meta_wd.len    = '0;
							end
						end
						cst_pkg::FN_WAIT: begin
							if (cnt_dec[CW]) begin
								// count would go negative: queue the caller
								if (q_full) begin
									res_code_d = cst_pkg::RC_FULL;
								end else begin
									meta_we       = 1'b1;
									meta_wd.count = sat_cnt(cnt_dec);
									meta_wd.len   = cur.len + LEN_W'(1);
									pid_we        = 1'b1;
									res_blocks_d  = 1'b1;
								end
							end else begin
								meta_we       = 1'b1;
								meta_wd.count = cnt_dec[CW-1:0];
							end
						end
						cst_pkg::FN_POST: begin
							meta_we       = 1'b1;
							meta_wd.count = inc_sat;
							if ((inc_sat[CW-1] || inc_sat == '0) && cur.len != '0) begin
								// dequeue the oldest waiter; pid arrives next cycle
								meta_wd.head = wrap_inc(cur.head);
								meta_wd.len  = cur.len - LEN_W'(1);
								pid_re       = 1'b1;
								meta_nxt     = ST_WAKE;
							end
						end
						cst_pkg::FN_DELETE: begin
							meta_we = 1'b1;
							meta_wd = '0;
							if (cur.len != '0) begin
								pid_re   = 1'b1;
								del_go   = 1'b1;
								meta_nxt = ST_DEL;
							end
						end
						cst_pkg::FN_OPEN: begin
							if (!cur.exists) begin
								res_code_d = cst_pkg::RC_NOT_OPEN;
							end
						end
						default: begin
							res_code_d = cst_pkg::RC_INVALID;
						end
					endcase
				end
			end
			ST_RESP: begin
				out_load     = out_free;
				out_code_d   = res_code_q;
				out_blocks_d = res_blocks_q;
				done         = out_free;
			end
			ST_WAKE: begin
				out_load = out_free;
				out_wv_d = 1'b1;
				done     = out_free;
			end
			ST_DEL: begin
				out_load   = out_free;
				out_wv_d   = 1'b1;
				out_last_d = (del_left_q == LEN_W'(1));
				done       = out_free && out_last_d;
				// fetch the next queued pid while this one is handed out
				pid_re     = out_free && !out_last_d;
				pid_raddr  = pid_addr(sem_q, del_ptr_q);
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE) || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			func_q       <= '0;
			ok_q         <= 1'b0;
			sem_q        <= '0;
			init_q       <= '0;
			pid_q        <= '0;
			res_code_q   <= cst_pkg::RC_OK;
			res_blocks_q <= 1'b0;
			del_left_q   <= '0;
			del_ptr_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_code_q   <= cst_pkg::RC_OK;
			rsp_blocks_q <= 1'b0;
			rsp_wv_q     <= 1'b0;
			rsp_pid_q    <= '0;
			rsp_last_q   <= 1'b0;
			meta_vld_q   <= '0;
		end else begin
			if (acc) begin
				func_q <= req.func;
				ok_q   <= id_ok && fn_ok;
				sem_q  <= acc_idx;
				init_q <= req.init_count;
				pid_q  <= req.caller_pid[PW-1:0];
			end

			if (meta_we) begin
				meta_vld_q[sem_q] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_META;
					end
				end
				ST_META: begin
					state_q      <= meta_nxt;
					res_code_q   <= res_code_d;
					res_blocks_q <= res_blocks_d;
					if (del_go) begin
						del_left_q <= cur.len;
						del_ptr_q  <= wrap_inc(cur.head);
					end
				end
				ST_RESP, ST_WAKE: begin
					if (done) begin
						state_q <= acc ? ST_META : ST_IDLE;
					end
				end
				ST_DEL: begin
					if (done) begin
						state_q <= acc ? ST_META : ST_IDLE;
					end else if (out_load) begin
						del_left_q <= del_left_q - LEN_W'(1);
						del_ptr_q  <= wrap_inc(del_ptr_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				rsp_valid_q  <= 1'b1;
				rsp_code_q   <= out_code_d;
				rsp_blocks_q <= out_blocks_d;
				rsp_wv_q     <= out_wv_d;
				rsp_pid_q    <= out_wv_d ? PIDW'(pid_rdata) : '0;
				rsp_last_q   <= out_last_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// metadata RAM: written back in the decide cycle, read on request accept
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[sem_q] <= meta_wd;
		end
		if (acc) begin
			meta_rdata_q <= meta_mem[acc_idx];
			meta_rvld_q  <= meta_vld_q[acc_idx];
		end
	end

	cst_pid_ram #(
		.DEPTH (PQ_DEPTH),
		.WIDTH (PW)
	) u_pid_ram (
		.clk   (clk),
		.we    (pid_we),
		.waddr (pid_waddr),
		.wdata (pid_q),
		.re    (pid_re),
		.raddr (pid_raddr),
		.rdata (pid_rdata)
	);

	assign rsp.valid         = rsp_valid_q;
	assign rsp.result_code   = rsp_code_q;
	assign rsp.caller_blocks = rsp_blocks_q;
	assign rsp.wake_valid    = rsp_wv_q;
	assign rsp.wake_pid      = rsp_pid_q;
	assign rsp.last          = rsp_last_q;

	// write-back and a new metadata read never share an edge
	`CST_ASSERT_NOW(a_meta_no_overlap, clk, arst_n, meta_we, !acc,
		"metadata write coincides with request accept")
	// a taken request is decided in the following cycle
	`CST_ASSERT_NEXT(a_accept_to_meta, clk, arst_n, acc, state_q == ST_META,
		"accepted request did not reach the decide cycle")
	// only the delete walk produces non-final results
	`CST_ASSERT_NOW(a_nonlast_from_del, clk, arst_n, rsp.valid && !rsp.last,
		state_q == ST_DEL, "non-final result outside a delete")
	// the walk never runs with nothing left to hand out
	`CST_ASSERT_NOW(a_del_nonempty, clk, arst_n, state_q == ST_DEL,
		del_left_q != '0, "delete walk with empty remainder")

endmodule
